FILE: hdl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg: shared types for the indexed list store
// Request kinds, status codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package ils_pkg;

   // Kind of request carried on req_type.
   typedef enum logic [1:0] {
      REQ_APPEND = 2'd0,
      REQ_READ   = 2'd1,
      REQ_DELETE = 2'd2
   } req_kind_type;

   // Status returned with every response.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // Per-cell control from the list controller.
   typedef struct packed {
      logic write_new;   // load the appended word
      logic shift_down;  // take the word of the next cell up
   } cell_ctrl_type;

endpackage

FILE: hdl/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell: one storage cell of the list
// Holds one word; loads an appended word or the word of its upper neighbor.
// ----------------------------------------------------------------------------
module ils_cell
   import ils_pkg::*;
#(
   parameter int WORD_WIDTH = 32
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [WORD_WIDTH-1:0] new_word,
   input  logic [WORD_WIDTH-1:0] next_word,
   output logic [WORD_WIDTH-1:0] word
);

   logic [WORD_WIDTH-1:0] word_ff;
   logic [WORD_WIDTH-1:0] word_in;

   // An append writes the new word; a delete at or below this cell pulls the neighbor down.
   always_comb begin
      word_in = word_ff;
      if (ctrl.write_new) begin
         word_in = new_word;
      end else if (ctrl.shift_down) begin
         word_in = next_word;
      end
   end

   // The payload needs no reset: entries above the length are never read.
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

FILE: hdl/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store: ordered list with append, indexed read and delete
// A row of cells holds the list; a delete shifts all later cells down at once.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge where start is high and busy is low.
//   req_type selects append (word req_data_in goes to the tail), read at
//   req_index, or delete at req_index. busy stays low, so a new request may
//   be issued in every cycle.
//   Each request yields exactly one response in the next cycle: rsp_valid is
//   high for that single cycle with rsp_status, rsp_read_word and
//   rsp_length (the length after the request). The receiver cannot stall;
//   it must take the response in that cycle.
//   Throughput is one request per cycle for all three kinds, because every
//   cell updates in parallel from its own neighbor.
//   An append to a full list returns full; a read or delete at or beyond
//   the length returns bad index. Failed requests change nothing.
//   Reset empties the list; stored words are not cleared, since no word
//   above the length is ever read.
// ----------------------------------------------------------------------------
module indexed_list_store
   import ils_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int WORD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [5:0]  req_index,
   input  logic [31:0] req_data_in,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_read_word,
   output logic [6:0]  rsp_length
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

   logic                  accept;
   req_kind_type          kind;
   logic [CMP_W-1:0]      idx_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic                  idx_ok;
   logic                  full;
   logic [63:0]           data_wide;
   logic [WORD_WIDTH-1:0] new_word;
   logic [WORD_WIDTH-1:0] cell_word [CAPACITY];
   cell_ctrl_type         cell_ctrl [CAPACITY];
   logic [CAPACITY-1:0]   wr_sel;
   logic [WORD_WIDTH-1:0] rd_word;
   logic [63:0]           rd_wide;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic [1:0]       rsp_status_ff;
   logic [1:0]       rsp_status_in;
   logic [31:0]      rsp_read_word_ff;
   logic [31:0]      rsp_read_word_in;
   logic [6:0]       rsp_length_ff;

   // Request decode and range checks.
   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign kind      = req_kind_type'(req_type);
   assign idx_ext   = CMP_W'(req_index);
   assign cnt_ext   = CMP_W'(count_ff);
   assign idx_ok    = idx_ext < cnt_ext;
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign data_wide = 64'(req_data_in);
   assign new_word  = data_wide[WORD_WIDTH-1:0];

   // Per-cell control: the tail cell takes an append; cells at or above the
   // deleted place and below the last entry take their upper neighbor.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ctrl[i].write_new  = accept && (kind == REQ_APPEND) && !full
                                   && (count_ff == CNT_W'(i));
         cell_ctrl[i].shift_down = accept && (kind == REQ_DELETE) && idx_ok
                                   && (idx_ext <= CMP_W'(i))
                                   && (cnt_ext > CMP_W'(i + 1));
         wr_sel[i]               = cell_ctrl[i].write_new;
      end
   end

   // The row of cells, each fed by its upper neighbor.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [WORD_WIDTH-1:0] above;
      if (g == CAPACITY - 1) begin : g_top
         assign above = '0;
      end else begin : g_mid
         assign above = cell_word[g + 1];
      end
      ils_cell #(
         .WORD_WIDTH(WORD_WIDTH)
      ) u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl[g]),
         .new_word (new_word),
         .next_word(above),
         .word     (cell_word[g])
      );
   end

   // Read select: each cell contributes its word when its place matches.
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (idx_ext == CMP_W'(i)) begin
            rd_word = rd_word | cell_word[i];
         end
      end
   end
   assign rd_wide = 64'(rd_word);

   // Next length and response contents.
   always_comb begin
      count_in         = count_ff;
      rsp_status_in    = ST_OK;
      rsp_read_word_in = '0;
      case (kind)
         REQ_APPEND: begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         REQ_READ: begin
            if (idx_ok) begin
               rsp_read_word_in = rd_wide[31:0];
            end else begin
               rsp_status_in = ST_BAD_INDEX;
            end
         end
         REQ_DELETE: begin
            if (idx_ok) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               rsp_status_in = ST_BAD_INDEX;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Control state: length and response strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_read_word_ff <= rsp_read_word_in;
         rsp_length_ff    <= 7'(count_in);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_word = rsp_read_word_ff;
   assign rsp_length    = rsp_length_ff;

`ifndef SYNTH
   // The length never passes the capacity.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list length exceeds capacity");

   // At most one cell takes an appended word.
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(wr_sel))
      else $error("more than one cell written by an append");

   // Every request gives exactly one response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("request without response");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid_ff)
      else $error("response without request");

   // A rejected request leaves the length as it was.
   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      accept && (rsp_status_in != ST_OK) |=> count_ff == $past(count_ff))
      else $error("rejected request changed the length");
`endif

endmodule
